[hw/rtl/uclr_pkg.sv]
// Shared types, codes and constants of the command-line receiver.
package uclr_pkg;

  localparam int LINE_DEPTH_DEFAULT = 32;
  localparam int MAX_RESULTS = 34;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam logic [2:0] CFG_CAPITAL_FIRST = 3'd0;
  localparam logic [2:0] CFG_CAPITAL_LAST  = 3'd1;
  localparam logic [2:0] CFG_SMALL_FIRST   = 3'd2;
  localparam logic [2:0] CFG_SMALL_LAST    = 3'd3;
  localparam logic [2:0] CFG_CAPITAL_MASK  = 3'd4;
  localparam logic [2:0] CFG_SMALL_MASK    = 3'd5;

  localparam logic [7:0] RST_CAPITAL_FIRST = 8'd65;
  localparam logic [7:0] RST_CAPITAL_LAST  = 8'd90;
  localparam logic [7:0] RST_SMALL_FIRST   = 8'd97;
  localparam logic [7:0] RST_SMALL_LAST    = 8'd122;

  typedef enum logic [2:0] {
    KIND_STATUS  = 3'd0,
    KIND_CAPITAL = 3'd1,
    KIND_LINE    = 3'd2,
    KIND_ARG     = 3'd3,
    KIND_UNREG   = 3'd4,
    KIND_NONE    = 3'd5
  } kind_t;

  // Where the next result beat takes its kind and code from.
  typedef enum logic [2:0] {
    SRC_STATUS,
    SRC_CAPITAL,
    SRC_NONE,
    SRC_BLANK,
    SRC_LINE_UNREG,
    SRC_HELD
  } src_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_ARG_RD,
    ST_ARG_CHK
  } state_t;

  typedef struct packed {
    logic load_in;
    logic recv;
    logic push;
    src_t src;
    logic last;
    logic clr_cap;
    logic clr_line;
    logic rd_en;
    logic idx_inc;
    logic hold_line;
    logic hold_arg;
  } cmd_t;

  typedef struct packed {
    logic opcode;
    logic cap_pend;
    logic line_pend;
    logic out_free;
    logic idx_at_len;
    logic is_blank;
    logic rd_zero;
    logic small_ok;
    logic cnt_room;
  } stat_t;

endpackage

[hw/rtl/uart_command_line_receiver_top.sv]
// Top level of the serial console command-line receiver.
//
// The input channel carries one beat per received serial byte (s_tuser low,
// byte in s_tdata) or per service request (s_tuser high). Capital-range bytes
// latch a single-key command; other bytes are edited into a line store.
// The output channel returns result beats: the kind in m_tuser, the command
// or character and the events-pending flag in m_tdata, and m_tlast on the
// final beat caused by one input beat.
// A received byte is accepted in the idle state; in the start state its status
// beat is loaded into the output register once that register is free. A service
// request is accepted, then starts (emitting any capital command), then walks
// the line store through one registered read port: each LF or space slot, the
// command letter, each argument character and the closing zero pass a read and
// a check state. A beat that waits for the output register holds the walk.
// The output register holds one beat; while m_tready is low the sequencer
// waits before each push. The input channel is ready only in the idle state.
// Reset is synchronous: it clears pending commands and the line length and
// restores the register defaults. The line store itself needs no clearing,
// since only slots written since the last line start are ever read.
module uart_command_line_receiver_top #(
  parameter int LINE_DEPTH = uclr_pkg::LINE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port; register index as listed in the register map.
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_tuser,   // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] code, [8] events_pending, [15:9] zero
  output logic [2:0]  m_tuser,   // [2:0] kind
  output logic        m_tlast
);

  uclr_pkg::cmd_t  cmd;
  uclr_pkg::stat_t stat;

  // The sequencer owns the input handshake and the order of result beats.
  uclr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds registers, the line store and the output register.
  uclr_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

[hw/rtl/uclr_ctrl.sv]
// Sequencer of the command-line receiver: input handshake and service walk.
module uclr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  uclr_pkg::stat_t stat,
  output uclr_pkg::cmd_t  cmd
);

  uclr_pkg::state_t state;
  uclr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uclr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    cmd.load_in   = 1'b0;
    cmd.recv      = 1'b0;
    cmd.push      = 1'b0;
    cmd.src       = uclr_pkg::SRC_STATUS;
    cmd.last      = 1'b0;
    cmd.clr_cap   = 1'b0;
    cmd.clr_line  = 1'b0;
    cmd.rd_en     = 1'b0;
    cmd.idx_inc   = 1'b0;
    cmd.hold_line = 1'b0;
    cmd.hold_arg  = 1'b0;
    case (state)
      uclr_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = uclr_pkg::ST_START;
        end
      end
      uclr_pkg::ST_START: begin
        if (!stat.opcode) begin
          if (stat.out_free) begin
            cmd.recv   = 1'b1;
            cmd.push   = 1'b1;
            cmd.src    = uclr_pkg::SRC_STATUS;
            cmd.last   = 1'b1;
            state_next = uclr_pkg::ST_IDLE;
          end
        end else if (stat.cap_pend) begin
          if (stat.out_free) begin
            cmd.push    = 1'b1;
            cmd.src     = uclr_pkg::SRC_CAPITAL;
            cmd.last    = !stat.line_pend;
            cmd.clr_cap = 1'b1;
            state_next  = stat.line_pend ? uclr_pkg::ST_SCAN_RD : uclr_pkg::ST_IDLE;
          end
        end else if (stat.line_pend) begin
          state_next = uclr_pkg::ST_SCAN_RD;
        end else if (stat.out_free) begin
          cmd.push   = 1'b1;
          cmd.src    = uclr_pkg::SRC_NONE;
          cmd.last   = 1'b1;
          state_next = uclr_pkg::ST_IDLE;
        end
      end
      uclr_pkg::ST_SCAN_RD: begin
        if (stat.idx_at_len) begin
          if (stat.out_free) begin
            cmd.push     = 1'b1;
            cmd.src      = uclr_pkg::SRC_BLANK;
            cmd.last     = 1'b1;
            cmd.clr_line = 1'b1;
            state_next   = uclr_pkg::ST_IDLE;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = uclr_pkg::ST_SCAN_CHK;
        end
      end
      uclr_pkg::ST_SCAN_CHK: begin
        if (stat.is_blank) begin
          cmd.idx_inc = 1'b1;
          state_next  = uclr_pkg::ST_SCAN_RD;
        end else if (stat.small_ok) begin
          cmd.hold_line = 1'b1;
          cmd.idx_inc   = 1'b1;
          state_next    = uclr_pkg::ST_ARG_RD;
        end else if (stat.out_free) begin
          cmd.push     = 1'b1;
          cmd.src      = uclr_pkg::SRC_LINE_UNREG;
          cmd.last     = 1'b1;
          cmd.clr_line = 1'b1;
          state_next   = uclr_pkg::ST_IDLE;
        end
      end
      uclr_pkg::ST_ARG_RD: begin
        if (stat.idx_at_len || !stat.cnt_room) begin
          if (stat.out_free) begin
            cmd.push     = 1'b1;
            cmd.src      = uclr_pkg::SRC_HELD;
            cmd.last     = 1'b1;
            cmd.clr_line = 1'b1;
            state_next   = uclr_pkg::ST_IDLE;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = uclr_pkg::ST_ARG_CHK;
        end
      end
      uclr_pkg::ST_ARG_CHK: begin
        if (stat.out_free) begin
          cmd.push = 1'b1;
          cmd.src  = uclr_pkg::SRC_HELD;
          if (stat.rd_zero) begin
            cmd.last     = 1'b1;
            cmd.clr_line = 1'b1;
            state_next   = uclr_pkg::ST_IDLE;
          end else begin
            cmd.hold_arg = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_next   = uclr_pkg::ST_ARG_RD;
          end
        end
      end
      default: begin
        state_next = uclr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/uclr_datapath.sv]
// Datapath of the command-line receiver: registers, line store and result register.
module uclr_datapath #(
  parameter int LINE_DEPTH = uclr_pkg::LINE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  input  logic [7:0]      s_tdata,
  input  logic [0:0]      s_tuser,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [15:0]     m_tdata,
  output logic [2:0]      m_tuser,
  output logic            m_tlast,
  input  uclr_pkg::cmd_t  cmd,
  output uclr_pkg::stat_t stat
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int LW = $clog2(LINE_DEPTH + 1);

  function automatic logic has_handler(input logic [7:0] c, input logic [7:0] lo,
                                       input logic [7:0] hi, input logic [31:0] mask);
    logic [7:0] off;
    off = c - lo;
    return (c >= lo) && (c <= hi) && (off[7:5] == 3'd0) && mask[off[4:0]];
  endfunction

  logic [7:0]  capital_first;
  logic [7:0]  capital_last;
  logic [7:0]  small_first;
  logic [7:0]  small_last;
  logic [31:0] capital_mask;
  logic [31:0] small_mask;

  logic        in_opcode;
  logic [7:0]  in_byte;
  logic        capital_pending;
  logic        line_pending;
  logic [7:0]  capital_command;
  logic [LW-1:0] line_length;
  logic [LW-1:0] idx;
  logic [uclr_pkg::CNT_W-1:0] cnt;

  logic [7:0]  line_store [LINE_DEPTH];
  logic [7:0]  rd_data;
  logic        wr_en;
  logic [7:0]  wr_data;

  uclr_pkg::kind_t held_kind;
  logic [7:0]      held_code;

  logic            out_valid;
  uclr_pkg::kind_t out_kind;
  logic [7:0]      out_code;
  logic            out_ep;
  logic            out_last;

  logic            is_cap;
  logic            has_room;
  logic            ep_recv;
  uclr_pkg::kind_t push_kind;
  logic [7:0]      push_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      capital_first <= uclr_pkg::RST_CAPITAL_FIRST;
      capital_last  <= uclr_pkg::RST_CAPITAL_LAST;
      small_first   <= uclr_pkg::RST_SMALL_FIRST;
      small_last    <= uclr_pkg::RST_SMALL_LAST;
      capital_mask  <= 32'd0;
      small_mask    <= 32'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        uclr_pkg::CFG_CAPITAL_FIRST: capital_first <= cfg_data[7:0];
        uclr_pkg::CFG_CAPITAL_LAST:  capital_last  <= cfg_data[7:0];
        uclr_pkg::CFG_SMALL_FIRST:   small_first   <= cfg_data[7:0];
        uclr_pkg::CFG_SMALL_LAST:    small_last    <= cfg_data[7:0];
        uclr_pkg::CFG_CAPITAL_MASK:  capital_mask  <= cfg_data;
        uclr_pkg::CFG_SMALL_MASK:    small_mask    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Line editing decisions for the latched byte.
  always_comb begin
    is_cap   = (in_byte >= capital_first) && (in_byte <= capital_last);
    has_room = line_length < LW'(LINE_DEPTH);
    ep_recv  = capital_pending | is_cap | line_pending |
               (!is_cap && (in_byte == uclr_pkg::CH_CR));
    wr_en    = cmd.recv && !is_cap && !line_pending && has_room &&
               (in_byte != uclr_pkg::CH_BS);
    wr_data  = (in_byte == uclr_pkg::CH_CR) ? uclr_pkg::CH_NUL : in_byte;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_store[line_length[AW-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= line_store[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_opcode <= s_tuser[0];
      in_byte   <= s_tdata;
    end
    if (cmd.hold_line) begin
      held_kind <= uclr_pkg::KIND_LINE;
      held_code <= rd_data;
    end else if (cmd.hold_arg) begin
      held_kind <= uclr_pkg::KIND_ARG;
      held_code <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capital_pending <= 1'b0;
      line_pending    <= 1'b0;
      capital_command <= 8'd0;
      line_length     <= '0;
      idx             <= '0;
      cnt             <= '0;
    end else begin
      if (cmd.load_in) begin
        idx <= '0;
        cnt <= '0;
      end else begin
        if (cmd.idx_inc) begin
          idx <= idx + LW'(1);
        end
        if (cmd.hold_line || cmd.hold_arg ||
            (cmd.push && (cmd.src == uclr_pkg::SRC_CAPITAL))) begin
          cnt <= cnt + uclr_pkg::CNT_W'(1);
        end
      end
      if (cmd.recv) begin
        if (is_cap) begin
          if (!capital_pending) begin
            capital_command <= in_byte;
            capital_pending <= 1'b1;
          end
        end else if (!line_pending) begin
          if (in_byte == uclr_pkg::CH_CR) begin
            line_pending <= 1'b1;
            if (has_room) begin
              line_length <= line_length + LW'(1);
            end
          end else if (in_byte == uclr_pkg::CH_BS) begin
            if (line_length != '0) begin
              line_length <= line_length - LW'(1);
            end
          end else if (line_length < LW'(LINE_DEPTH - 1)) begin
            line_length <= line_length + LW'(1);
          end
        end
      end
      if (cmd.clr_cap) begin
        capital_pending <= 1'b0;
      end
      if (cmd.clr_line) begin
        line_pending <= 1'b0;
        line_length  <= '0;
      end
    end
  end

  always_comb begin
    case (cmd.src)
      uclr_pkg::SRC_STATUS: begin
        push_kind = uclr_pkg::KIND_STATUS;
        push_code = in_byte;
      end
      uclr_pkg::SRC_CAPITAL: begin
        push_kind = has_handler(capital_command, capital_first, capital_last,
                                capital_mask) ? uclr_pkg::KIND_CAPITAL : uclr_pkg::KIND_UNREG;
        push_code = capital_command;
      end
      uclr_pkg::SRC_NONE: begin
        push_kind = uclr_pkg::KIND_NONE;
        push_code = 8'd0;
      end
      uclr_pkg::SRC_BLANK: begin
        push_kind = uclr_pkg::KIND_UNREG;
        push_code = 8'd0;
      end
      uclr_pkg::SRC_LINE_UNREG: begin
        push_kind = uclr_pkg::KIND_UNREG;
        push_code = rd_data;
      end
      uclr_pkg::SRC_HELD: begin
        push_kind = held_kind;
        push_code = held_code;
      end
      default: begin
        push_kind = uclr_pkg::KIND_NONE;
        push_code = 8'd0;
      end
    endcase
  end

  // A service request clears both pending flags, so its beats report none pending.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (cmd.push) begin
      out_kind <= push_kind;
      out_code <= push_code;
      out_ep   <= (cmd.src == uclr_pkg::SRC_STATUS) ? ep_recv : 1'b0;
      out_last <= cmd.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_ep, out_code};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  always_comb begin
    stat.opcode     = in_opcode;
    stat.cap_pend   = capital_pending;
    stat.line_pend  = line_pending;
    stat.out_free   = !out_valid || m_tready;
    stat.idx_at_len = idx >= line_length;
    stat.is_blank   = (rd_data == uclr_pkg::CH_LF) || (rd_data == uclr_pkg::CH_SPACE);
    stat.rd_zero    = rd_data == uclr_pkg::CH_NUL;
    stat.small_ok   = has_handler(rd_data, small_first, small_last, small_mask);
    stat.cnt_room   = cnt < uclr_pkg::CNT_W'(uclr_pkg::MAX_RESULTS);
  end

endmodule
